### rtl/anf_pkg.sv
package anf_pkg;

    // field widths fixed by the interface
    localparam int ORDER_W  = 12;
    localparam int SHIFT_W  = 5;
    localparam int SAMPLE_W = 16;

    // configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_FILTER_ORDER = 2'd0;
    localparam logic [1:0] REG_ROUND_SHIFT  = 2'd1;
    localparam logic [1:0] REG_DELTA_RULE   = 2'd2;

    // register values after reset
    localparam logic [ORDER_W-1:0] FILTER_ORDER_RST = 12'd16;
    localparam logic [SHIFT_W-1:0] ROUND_SHIFT_RST  = 5'd11;

    // smallest order that enables prediction
    localparam int MIN_ORDER = 16;

    // step magnitudes and saturation limits
    localparam logic [SAMPLE_W-1:0] STEP_LARGE = 16'd32;
    localparam logic [SAMPLE_W-1:0] STEP_MID   = 16'd16;
    localparam logic [SAMPLE_W-1:0] STEP_SMALL = 16'd8;
    localparam logic [SAMPLE_W-1:0] STEP_OLDER = 16'd4;
    localparam logic [SAMPLE_W-1:0] SAT_POS    = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG    = 16'h8000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_MAC,
        ST_DRAIN,
        ST_FIN_SUM,
        ST_FIN_WRITE,
        ST_HALVE_RD,
        ST_HALVE_WR
    } state_t;

    // result of the step rule for one output
    typedef struct packed {
        logic [SAMPLE_W-1:0] sat_sample;
        logic [SAMPLE_W-1:0] step;
        logic [31:0]         avg_next;
    } post_t;

    // distance back of each step that gets halved
    function automatic logic [3:0] halve_offset(input logic newer, input logic [1:0] idx);
        logic [3:0] off;
        off = 4'd8;
        if (newer) begin
            case (idx)
                2'd0:    off = 4'd1;
                2'd1:    off = 4'd2;
                default: off = 4'd8;
            endcase
        end else begin
            case (idx)
                2'd0:    off = 4'd4;
                default: off = 4'd8;
            endcase
        end
        return off;
    endfunction

endpackage

### rtl/anf_step_rule.sv
module anf_step_rule (
    input  logic signed [31:0] sample_i,
    input  logic [31:0]        avg_i,
    input  logic               newer_i,
    output anf_pkg::post_t     post_o
);
    import anf_pkg::*;

    logic               is_neg;
    logic               is_zero;
    logic               ovf;
    logic [31:0]        mag_a;
    logic [33:0]        a_ext;
    logic [33:0]        a3;
    logic [33:0]        avg3;
    logic [33:0]        avg4;
    logic [15:0]        step_mag;
    logic signed [32:0] diff;
    logic signed [32:0] diff_q;

    always_comb begin
        is_neg  = sample_i[31];
        is_zero = (sample_i == 32'sd0);
        ovf     = (sample_i[31:15] != {17{sample_i[31]}});

        // saturated history value
        if (!ovf) begin
            post_o.sat_sample = sample_i[15:0];
        end else if (is_neg) begin
            post_o.sat_sample = SAT_NEG;
        end else begin
            post_o.sat_sample = SAT_POS;
        end

        // exact magnitude, most negative value gives 2^31
        mag_a = is_neg ? (~sample_i + 32'd1) : sample_i;
        a_ext = {2'b00, mag_a};
        a3    = {2'b00, mag_a} + {1'b0, mag_a, 1'b0};
        avg3  = {2'b00, avg_i} + {1'b0, avg_i, 1'b0};
        avg4  = {avg_i, 2'b00};

        // a > floor(4*avg/3) is the same as 3*a > 4*avg
        if (a_ext > avg3) begin
            step_mag = STEP_LARGE;
        end else if (a3 > avg4) begin
            step_mag = STEP_MID;
        end else if (!is_zero) begin
            step_mag = STEP_SMALL;
        end else begin
            step_mag = '0;
        end

        // step sign opposes the output sign
        if (newer_i) begin
            post_o.step = (!is_neg && !is_zero) ? (16'd0 - step_mag) : step_mag;
        end else if (is_zero) begin
            post_o.step = '0;
        end else if (is_neg) begin
            post_o.step = STEP_OLDER;
        end else begin
            post_o.step = 16'd0 - STEP_OLDER;
        end

        // running average moves by a sixteenth, truncated toward zero
        diff   = $signed({1'b0, mag_a}) - $signed({1'b0, avg_i});
        diff_q = diff[32] ? ((diff + 33'sd15) >>> 4) : (diff >>> 4);
        post_o.avg_next = avg_i + diff_q[31:0];
    end

endmodule

### rtl/adaptive_nn_filter_decode.sv
// an accepted item runs START, a tap walk in MAC and DRAIN (skipped below order 16),
// FIN_SUM and FIN_WRITE, then halves three older steps (newer step rule) or two (older)
// before s_ready returns; the walk reads one tap per cycle through the read ports of
// the history and weight memories; FIN_WRITE sets m_valid once the output is free, so a
// stalled result holds the item there; clear_first adds a clearing pass of all MAX_ORDER
// slots first; after reset such a pass runs with s_ready low; config always taken
module adaptive_nn_filter_decode #(
    parameter int MAX_ORDER = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_residual_in,
    input  logic               s_clear_first,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import anf_pkg::*;

    localparam int AW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int SW = AW + 2;
    localparam int OW = (CW > ORDER_W) ? CW : ORDER_W;
    localparam logic [OW-1:0] MAX_ORDER_O = OW'(MAX_ORDER);
    localparam logic [SW-1:0] MAX_ORDER_S = SW'(MAX_ORDER);
    localparam logic [AW-1:0] LAST_SLOT   = AW'(MAX_ORDER - 1);

    // history word: sample in the upper half, step in the lower
    logic [31:0] hist_ram [MAX_ORDER];
    logic [15:0] wgt_ram  [MAX_ORDER];

    state_t state_reg, state_next;

    logic [ORDER_W-1:0] filter_order_reg;
    logic [SHIFT_W-1:0] round_shift_reg;
    logic               newer_rule_reg;

    logic [AW-1:0]      pos_reg;
    logic [31:0]        avg_reg;
    logic [AW-1:0]      clr_idx_reg;
    logic               item_pend_reg;
    logic signed [31:0] res_reg;
    logic [CW-1:0]      order_cnt_reg;
    logic [CW-1:0]      tap_idx_reg;
    logic [AW-1:0]      slot_reg;
    logic               rd_v_reg;
    logic [AW-1:0]      tap_d1_reg;
    logic signed [31:0] prod_reg;
    logic               prod_v_reg;
    logic [31:0]        dot_reg;
    logic signed [31:0] o_reg;
    logic [1:0]         hidx_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_data_reg;
    logic [31:0]        hist_rdata_reg;
    logic [15:0]        wgt_rdata_reg;

    logic [OW-1:0] order_ext;
    logic [CW-1:0] eff_order;
    logic          mac_en;
    logic [SW-1:0] start_tmp;
    logic [AW-1:0] start_slot;
    logic [3:0]    halve_off;
    logic [SW-1:0] halve_tmp;
    logic [AW-1:0] halve_slot;
    logic          halve_last;
    logic          out_free;
    logic          cfg_wr;
    logic          accept;
    logic          fin_adv;

    logic [31:0] rnd_const;
    logic [31:0] sum_rnd;
    logic [31:0] pred;
    logic [31:0] o_sum;

    logic          issue;
    logic          hist_we;
    logic [AW-1:0] hist_waddr;
    logic [31:0]   hist_wdata;
    logic          hist_re;
    logic [AW-1:0] hist_raddr;
    logic          wgt_we;
    logic [AW-1:0] wgt_waddr;
    logic [15:0]   wgt_wdata;
    logic          wgt_re;
    logic [AW-1:0] wgt_raddr;
    logic [15:0]   wgt_upd;

    post_t post;

    // handshakes
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign fin_adv      = (state_reg == ST_FIN_WRITE) && out_free;
    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_FILTER_ORDER: prdata = 32'(filter_order_reg);
            REG_ROUND_SHIFT:  prdata = 32'(round_shift_reg);
            REG_DELTA_RULE:   prdata = 32'(newer_rule_reg);
            default:          prdata = '0;
        endcase
    end

    // order clamp and first ring slot of the window
    always_comb begin
        order_ext  = OW'(filter_order_reg);
        eff_order  = (order_ext > MAX_ORDER_O) ? CW'(MAX_ORDER_O) : CW'(order_ext);
        mac_en     = (eff_order >= CW'(MIN_ORDER));
        start_tmp  = SW'(pos_reg) + MAX_ORDER_S - SW'(eff_order);
        start_slot = (start_tmp >= MAX_ORDER_S) ? AW'(start_tmp - MAX_ORDER_S) : AW'(start_tmp);
    end

    // ring slot of the step being halved
    always_comb begin
        halve_off  = halve_offset(newer_rule_reg, hidx_reg);
        halve_tmp  = SW'(pos_reg) + MAX_ORDER_S - SW'(halve_off);
        halve_slot = (halve_tmp >= MAX_ORDER_S) ? AW'(halve_tmp - MAX_ORDER_S) : AW'(halve_tmp);
        halve_last = newer_rule_reg ? (hidx_reg == 2'd2) : (hidx_reg == 2'd1);
    end

    // rounded, shifted prediction added to the residual
    always_comb begin
        rnd_const = (round_shift_reg == '0) ? '0 : (32'd1 << (round_shift_reg - 5'd1));
        sum_rnd   = dot_reg + rnd_const;
        pred      = $unsigned($signed(sum_rnd) >>> round_shift_reg);
        o_sum     = $unsigned(res_reg) + pred;
    end

    // weight moves against the residual sign
    always_comb begin
        if (res_reg[31]) begin
            wgt_upd = wgt_rdata_reg + hist_rdata_reg[15:0];
        end else if (res_reg != 32'sd0) begin
            wgt_upd = wgt_rdata_reg - hist_rdata_reg[15:0];
        end else begin
            wgt_upd = wgt_rdata_reg;
        end
    end

    anf_step_rule u_step_rule (
        .sample_i (o_reg),
        .avg_i    (avg_reg),
        .newer_i  (newer_rule_reg),
        .post_o   (post)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == LAST_SLOT) begin
                    state_next = item_pend_reg ? ST_START : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_clear_first ? ST_CLEAR : ST_START;
                end
            end
            ST_START: begin
                state_next = mac_en ? ST_MAC : ST_FIN_SUM;
            end
            ST_MAC: begin
                if (tap_idx_reg == order_cnt_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !prod_v_reg) begin
                    state_next = ST_FIN_SUM;
                end
            end
            ST_FIN_SUM: begin
                state_next = ST_FIN_WRITE;
            end
            ST_FIN_WRITE: begin
                if (out_free) begin
                    state_next = ST_HALVE_RD;
                end
            end
            ST_HALVE_RD: begin
                state_next = ST_HALVE_WR;
            end
            ST_HALVE_WR: begin
                state_next = halve_last ? ST_IDLE : ST_HALVE_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port controls
    always_comb begin
        issue      = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = pos_reg;
        hist_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = slot_reg;
        wgt_we     = 1'b0;
        wgt_waddr  = tap_d1_reg;
        wgt_wdata  = wgt_upd;
        wgt_re     = 1'b0;
        wgt_raddr  = tap_idx_reg[AW-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_idx_reg;
                wgt_we     = 1'b1;
                wgt_waddr  = clr_idx_reg;
                wgt_wdata  = '0;
            end
            ST_MAC: begin
                issue   = (tap_idx_reg < order_cnt_reg);
                hist_re = issue;
                wgt_re  = issue;
            end
            ST_FIN_WRITE: begin
                hist_we    = out_free;
                hist_wdata = {post.sat_sample, post.step};
            end
            ST_HALVE_RD: begin
                hist_re    = 1'b1;
                hist_raddr = halve_slot;
            end
            ST_HALVE_WR: begin
                hist_we    = 1'b1;
                hist_waddr = halve_slot;
                hist_wdata = {hist_rdata_reg[31:16], hist_rdata_reg[15], hist_rdata_reg[15:1]};
            end
            default: begin
            end
        endcase
        // write back the updated weight in the cycle after its read
        if (rd_v_reg) begin
            wgt_we    = 1'b1;
            wgt_waddr = tap_d1_reg;
            wgt_wdata = wgt_upd;
        end
    end

    // history memory
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_ram[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            hist_rdata_reg <= hist_ram[hist_raddr];
        end
    end

    // weight memory
    always_ff @(posedge aclk) begin
        if (wgt_we) begin
            wgt_ram[wgt_waddr] <= wgt_wdata;
        end
        if (wgt_re) begin
            wgt_rdata_reg <= wgt_ram[wgt_raddr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            filter_order_reg <= FILTER_ORDER_RST;
            round_shift_reg  <= ROUND_SHIFT_RST;
            newer_rule_reg   <= 1'b1;
            pos_reg          <= '0;
            avg_reg          <= '0;
            clr_idx_reg      <= '0;
            item_pend_reg    <= 1'b0;
            rd_v_reg         <= 1'b0;
            prod_v_reg       <= 1'b0;
            hidx_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;

            // configuration transaction
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_FILTER_ORDER: filter_order_reg <= pwdata[ORDER_W-1:0];
                    REG_ROUND_SHIFT:  round_shift_reg  <= pwdata[SHIFT_W-1:0];
                    REG_DELTA_RULE:   newer_rule_reg   <= pwdata[0];
                    default: begin
                    end
                endcase
            end

            // clearing pass
            if (accept && s_clear_first) begin
                clr_idx_reg   <= '0;
                pos_reg       <= '0;
                avg_reg       <= '0;
                item_pend_reg <= 1'b1;
            end else if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == LAST_SLOT) begin
                    item_pend_reg <= 1'b0;
                end
            end

            // running average
            if (fin_adv && newer_rule_reg) begin
                avg_reg <= post.avg_next;
            end

            // halving sequence and ring advance
            if (state_reg == ST_HALVE_WR) begin
                if (halve_last) begin
                    hidx_reg <= '0;
                    pos_reg  <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + AW'(1);
                end else begin
                    hidx_reg <= hidx_reg + 2'd1;
                end
            end

            // output register
            if (fin_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= s_residual_in;
        end

        // window setup
        if (state_reg == ST_START) begin
            order_cnt_reg <= eff_order;
            tap_idx_reg   <= '0;
            slot_reg      <= start_slot;
            dot_reg       <= '0;
        end

        // tap address walk
        if (issue) begin
            tap_idx_reg <= tap_idx_reg + CW'(1);
            tap_d1_reg  <= tap_idx_reg[AW-1:0];
            slot_reg    <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
        end

        // multiply, then accumulate
        if (rd_v_reg) begin
            prod_reg <= 32'($signed(hist_rdata_reg[31:16])) * 32'($signed(wgt_rdata_reg));
        end
        if (prod_v_reg) begin
            dot_reg <= dot_reg + $unsigned(prod_reg);
        end

        if (state_reg == ST_FIN_SUM) begin
            o_reg <= $signed(o_sum);
        end

        if (fin_adv) begin
            m_data_reg <= o_reg;
        end
    end

endmodule

### rtl/anf_checker.sv
module anf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_sample_out,
    input logic        pready
);

    // clearing pass holds off input after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // one item at a time: no second transaction on the next edge
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    // a result never appears on the edge right after acceptance
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result faster than the datapath allows");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_out)))
        else $error("stalled result changed or dropped");

    // configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind adaptive_nn_filter_decode anf_checker u_anf_checker (.*);
